FILE: src/cwc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the window controller.
`default_nettype none

package cwc_pkg;

    // Field widths.
    localparam int TIME_BITS = 32;
    localparam int WIN_BITS  = 16;
    localparam int CNT_BITS  = $clog2(TIME_BITS);

    // Window limit and threshold constants.
    localparam logic [WIN_BITS-1:0] MAX_WINDOW   = WIN_BITS'(65535);
    localparam logic [WIN_BITS-1:0] THRESH_RESET = WIN_BITS'(64);
    localparam logic [WIN_BITS-1:0] THRESH_MIN   = WIN_BITS'(2);
    localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(1);

    // Event kinds carried by the mode field.
    typedef enum logic [1:0] {
        MODE_ACK  = 2'd0,
        MODE_LOSS = 2'd1,
        MODE_MARK = 2'd2
    } mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the incoming word and form the elapsed time
        logic div_step;  // one restoring division step
        logic commit;    // update the state and load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;  // the incoming word is an avoidance ack with a known RTT
    } ctrl_status_t;

endpackage

`default_nettype wire

FILE: src/cwc_datapath.sv
// Datapath: window state, iterative elapsed/RTT divider and result register.
`default_nettype none

module cwc_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [1:0]                    s_mode,
    input  wire logic [cwc_pkg::TIME_BITS-1:0] s_now_ms,
    input  wire logic                          cfg_wr_en,
    input  wire logic [cwc_pkg::WIN_BITS-1:0]  cfg_wr_data,
    input  wire cwc_pkg::ctrl_cmd_t            cmd,
    output cwc_pkg::ctrl_status_t              status,
    output logic [cwc_pkg::WIN_BITS-1:0]       m_cwnd_pkts,
    output logic                               m_phase,
    output logic [cwc_pkg::WIN_BITS-1:0]       m_threshold,
    output logic                               m_window_changed
);
    import cwc_pkg::*;

    // Architectural state.
    logic                  phase_reg,  phase_next;
    logic [WIN_BITS-1:0]   window_reg, window_next;
    logic [WIN_BITS-1:0]   thresh_reg, thresh_next;
    logic [WIN_BITS-1:0]   base_reg,   base_next;
    logic [TIME_BITS-1:0]  stamp_reg,  stamp_next;
    logic [TIME_BITS-1:0]  rtt_reg,    rtt_next;

    // Captured word and divider registers. The quotient register holds the
    // elapsed time after a load and the quotient after the division steps.
    mode_t                 mode_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic [TIME_BITS-1:0]  quo_reg;
    logic [TIME_BITS-1:0]  rem_reg;

    // Result register.
    logic [WIN_BITS-1:0]   out_window_reg;
    logic                  out_phase_reg;
    logic [WIN_BITS-1:0]   out_thresh_reg;
    logic                  out_changed_reg;

    logic [TIME_BITS:0]    shift_w;
    logic                  fits_w;
    logic [TIME_BITS:0]    diff_w;
    logic [WIN_BITS-1:0]   half_w;
    logic [TIME_BITS:0]    sum_w;
    logic [WIN_BITS-1:0]   cand_w;

    assign status.need_div = (mode_t'(s_mode) == MODE_ACK) && phase_reg && (rtt_reg != '0);

    // One restoring division step.
    assign shift_w = {rem_reg, quo_reg[TIME_BITS-1]};
    assign fits_w  = shift_w >= {1'b0, rtt_reg};
    assign diff_w  = shift_w - {1'b0, rtt_reg};

    // Saturating base + quotient for congestion avoidance.
    assign sum_w  = {{(TIME_BITS + 1 - WIN_BITS){1'b0}}, base_reg} + {1'b0, quo_reg};
    assign cand_w = (sum_w >= {{(TIME_BITS + 1 - WIN_BITS){1'b0}}, MAX_WINDOW}) ?
                    MAX_WINDOW : sum_w[WIN_BITS-1:0];
    assign half_w = window_reg >> 1;

    always_comb begin
        phase_next  = phase_reg;
        window_next = window_reg;
        thresh_next = thresh_reg;
        base_next   = base_reg;
        stamp_next  = stamp_reg;
        rtt_next    = rtt_reg;
        unique case (mode_reg)
            MODE_MARK: begin
                stamp_next = now_reg;
            end
            MODE_LOSS: begin
                thresh_next = (half_w > THRESH_MIN) ? half_w : THRESH_MIN;
                if (!phase_reg) begin
                    phase_next = 1'b1;
                    base_next  = window_reg;
                    stamp_next = now_reg;
                end else begin
                    phase_next  = 1'b0;
                    window_next = WINDOW_RESET;
                end
            end
            MODE_ACK: begin
                if (!phase_reg) begin
                    if (rtt_reg == '0) begin
                        rtt_next = quo_reg;
                    end
                    if (window_reg < thresh_reg) begin
                        window_next = (window_reg >= MAX_WINDOW) ? MAX_WINDOW :
                                      window_reg + WIN_BITS'(1);
                    end else begin
                        phase_next = 1'b1;
                        base_next  = window_reg;
                        stamp_next = now_reg;
                    end
                end else if (rtt_reg != '0) begin
                    if (cand_w > window_reg) begin
                        window_next = cand_w;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= 1'b0;
            window_reg <= WINDOW_RESET;
            thresh_reg <= THRESH_RESET;
            base_reg   <= '0;
            stamp_reg  <= '0;
            rtt_reg    <= '0;
        end else if (cfg_wr_en) begin
            thresh_reg <= cfg_wr_data;
        end else if (cmd.commit) begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            thresh_reg <= thresh_next;
            base_reg   <= base_next;
            stamp_reg  <= stamp_next;
            rtt_reg    <= rtt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= mode_t'(s_mode);
            now_reg  <= s_now_ms;
            quo_reg  <= s_now_ms - stamp_reg;
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[TIME_BITS-2:0], fits_w};
            rem_reg <= fits_w ? diff_w[TIME_BITS-1:0] : shift_w[TIME_BITS-1:0];
        end
        if (cmd.commit) begin
            out_window_reg  <= window_next;
            out_phase_reg   <= phase_next;
            out_thresh_reg  <= thresh_next;
            out_changed_reg <= window_next != window_reg;
        end
    end

    assign m_cwnd_pkts      = out_window_reg;
    assign m_phase          = out_phase_reg;
    assign m_threshold      = out_thresh_reg;
    assign m_window_changed = out_changed_reg;

endmodule

`default_nettype wire

FILE: src/cwc_controller.sv
// Controller: sequences load, division steps and commit, and owns the handshakes.
`default_nettype none

module cwc_controller (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    input  wire cwc_pkg::ctrl_status_t status,
    output cwc_pkg::ctrl_cmd_t         cmd
);
    import cwc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_COMMIT
    } state_t;

    state_t              state_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                m_valid_reg;
    logic                accept_w;
    logic                out_free_w;

    assign s_ready    = state_reg == ST_IDLE;
    assign accept_w   = s_valid && s_ready;
    assign out_free_w = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;

    always_comb begin
        cmd.load     = accept_w;
        cmd.div_step = state_reg == ST_DIVIDE;
        cmd.commit   = (state_reg == ST_COMMIT) && out_free_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // A commit refills the result register in the cycle it is taken.
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept_w) begin
                        count_reg <= CNT_BITS'(TIME_BITS - 1);
                        state_reg <= status.need_div ? ST_DIVIDE : ST_COMMIT;
                    end
                end
                ST_DIVIDE: begin
                    count_reg <= count_reg - CNT_BITS'(1);
                    if (count_reg == '0) begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (out_free_w) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_w |=> !s_ready)
        else $error("controller stayed idle after accepting a word");

    a_divide_ends_in_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE && count_reg == '0) |=> state_reg == ST_COMMIT)
        else $error("division did not end in commit");

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("commit did not present a result word");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.commit)
        else $error("result word overwritten before it was taken");

endmodule

`default_nettype wire

FILE: src/congestion_window_controller_unit.sv
// Top level of the congestion window controller: controller plus datapath.
//
//  Channel  | Ports                                          | Direction
//  ---------+------------------------------------------------+----------
//  input    | s_valid, s_ready, s_mode, s_now_ms             | in
//  result   | m_valid, m_ready, m_cwnd_pkts, m_phase,        | out
//           | m_threshold, m_window_changed                  |
//  config   | cfg_wr_en, cfg_wr_data (slow start threshold)  | in
//
// A mark, a loss, an ack needing no division or an ignored mode goes from
// acceptance straight to the commit state. An ack in congestion avoidance
// with a measured RTT first passes the divide state: a bit-serial restoring
// divider forms elapsed/RTT, one quotient bit per cycle.
// The next word is accepted as soon as the controller is back in idle, even
// while the previous result still waits in the output register; a stalled
// result holds the next word in the commit state until it is taken.
// Reset is synchronous and active low: window 1, slow start, threshold 64.
// A configuration write loads the slow start threshold directly.
`default_nettype none

module congestion_window_controller_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write port.
    input  wire logic                          cfg_wr_en,
    input  wire logic [cwc_pkg::WIN_BITS-1:0]  cfg_wr_data,
    // Event input channel.
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_mode,
    input  wire logic [cwc_pkg::TIME_BITS-1:0] s_now_ms,
    // Result channel.
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [cwc_pkg::WIN_BITS-1:0]       m_cwnd_pkts,
    output logic                               m_phase,
    output logic [cwc_pkg::WIN_BITS-1:0]       m_threshold,
    output logic                               m_window_changed
);
    import cwc_pkg::*;

    // Commands flow from the controller to the datapath; the datapath reports
    // whether the word being accepted needs the divider.
    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    cwc_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cwc_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_mode           (s_mode),
        .s_now_ms         (s_now_ms),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .cmd              (cmd),
        .status           (status),
        .m_cwnd_pkts      (m_cwnd_pkts),
        .m_phase          (m_phase),
        .m_threshold      (m_threshold),
        .m_window_changed (m_window_changed)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the congestion window controller unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cwc_pkg::*;

    // Mode value 3 has no meaning; the block must leave its state alone.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Values of the phase bit in a result word.
    localparam logic PHASE_SLOW_START = 1'b0;
    localparam logic PHASE_AVOID      = 1'b1;

    // Words in each random phase, the long receiver hold-off, and the quiet
    // stretch at the end (longer than the divide path).
    localparam int PHASE_WORDS = 130;
    localparam int NUM_PHASES  = 10;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        logic [1:0]           mode;
        logic [TIME_BITS-1:0] now_ms;
    } cwnd_event_t;

    typedef struct packed {
        logic [WIN_BITS-1:0] cwnd_pkts;
        logic                phase;
        logic [WIN_BITS-1:0] threshold;
        logic                window_changed;
    } cwnd_result_t;

    // Every input of the block starts at a known value.
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [WIN_BITS-1:0]  cfg_wr_data = THRESH_RESET;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_mode      = MODE_ACK;
    logic [TIME_BITS-1:0] s_now_ms    = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [WIN_BITS-1:0]  m_cwnd_pkts;
    logic                 m_phase;
    logic [WIN_BITS-1:0]  m_threshold;
    logic                 m_window_changed;

    // Words waiting to be offered, and result words the block still owes us.
    cwnd_event_t  events_to_send[$];
    cwnd_result_t window_reports_due[$];
    int           mismatch_count = 0;

    // Idling knobs. The stimulus process sets them at phase boundaries; the
    // driver and the monitor only read them.
    int send_gap_pct  = 20;
    int recv_stall_pct = 20;
    int long_holds_requested = 0;

    // Our own copy of the controller state. Reset is applied only once, at
    // the start, so the declaration values are the post-reset state.
    logic                 cc_phase  = PHASE_SLOW_START;
    logic [WIN_BITS-1:0]  cwnd      = WINDOW_RESET;
    logic [WIN_BITS-1:0]  ssthresh  = THRESH_RESET;
    logic [WIN_BITS-1:0]  base_cwnd = '0;
    logic [TIME_BITS-1:0] mark_ms   = '0;
    logic [TIME_BITS-1:0] rtt_est   = '0;

    congestion_window_controller_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_now_ms         (s_now_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cwnd_pkts      (m_cwnd_pkts),
        .m_phase          (m_phase),
        .m_threshold      (m_threshold),
        .m_window_changed (m_window_changed)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Window growth saturates at the maximum in both phases.
    function automatic logic [WIN_BITS-1:0] sat_add(input logic [WIN_BITS-1:0] lhs,
                                                    input logic [TIME_BITS-1:0] inc);
        if (lhs >= MAX_WINDOW || inc >= TIME_BITS'(MAX_WINDOW - lhs)) begin
            return MAX_WINDOW;
        end
        return lhs + WIN_BITS'(inc);
    endfunction

    // Applies one accepted event to the state copy and returns the word the
    // block must produce for it.
    function automatic cwnd_result_t advance_window(input cwnd_event_t ev);
        logic [TIME_BITS-1:0] elapsed;
        logic [WIN_BITS-1:0]  prior;
        logic [WIN_BITS-1:0]  half;
        logic [WIN_BITS-1:0]  grown;
        cwnd_result_t         res;
        // Elapsed time wraps with the 32-bit millisecond counter.
        elapsed = ev.now_ms - mark_ms;
        prior   = cwnd;
        case (ev.mode)
            MODE_MARK: begin
                mark_ms = ev.now_ms;
            end
            MODE_LOSS: begin
                half     = cwnd >> 1;
                ssthresh = (half > THRESH_MIN) ? half : THRESH_MIN;
                if (cc_phase == PHASE_SLOW_START) begin
                    cc_phase  = PHASE_AVOID;
                    base_cwnd = cwnd;
                    mark_ms   = ev.now_ms;
                end else begin
                    cc_phase = PHASE_SLOW_START;
                    cwnd     = WINDOW_RESET;
                end
            end
            MODE_ACK: begin
                if (cc_phase == PHASE_SLOW_START) begin
                    // The RTT is taken once; a zero reading is retried later.
                    if (rtt_est == '0) begin
                        rtt_est = elapsed;
                    end
                    if (cwnd < ssthresh) begin
                        cwnd = sat_add(cwnd, TIME_BITS'(1));
                    end else begin
                        cc_phase  = PHASE_AVOID;
                        base_cwnd = cwnd;
                        mark_ms   = ev.now_ms;
                    end
                end else if (rtt_est != '0) begin
                    grown = sat_add(base_cwnd, elapsed / rtt_est);
                    if (grown > cwnd) begin
                        cwnd = grown;
                    end
                end
            end
            default: begin
                // Unused mode: nothing changes.
            end
        endcase
        res.cwnd_pkts      = cwnd;
        res.phase          = cc_phase;
        res.threshold      = ssthresh;
        res.window_changed = (cwnd != prior);
        return res;
    endfunction

    // Input driver. An accepted word is run through the predictor on the
    // edge that accepts it; the next word is then either offered or held
    // back for an idle burst of random length.
    always @(posedge aclk) begin : word_driver
        cwnd_event_t taken;
        cwnd_event_t nxt;
        logic        offer;
        int          send_gap_left;
        if (!aresetn) begin
            s_valid       <= 1'b0;
            send_gap_left = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                taken.mode   = s_mode;
                taken.now_ms = s_now_ms;
                window_reports_due.push_back(advance_window(taken));
            end
            offer = 1'b0;
            if (send_gap_left > 0) begin
                send_gap_left--;
            end else if (events_to_send.size() != 0) begin
                if ($urandom_range(0, 99) < send_gap_pct) begin
                    send_gap_left = $urandom_range(0, 10);
                end else begin
                    offer = 1'b1;
                end
            end
            if (offer) begin
                nxt = events_to_send.pop_front();
                s_mode   <= nxt.mode;
                s_now_ms <= nxt.now_ms;
            end
            // A word that stays valid is never lowered in between: this is
            // the only assignment to s_valid on this edge.
            s_valid <= offer;
        end
    end

    // Result monitor and receiver. Every accepted result word is checked
    // against the oldest outstanding prediction. The ready line stalls in
    // random bursts, and on request it holds off for a long stretch so the
    // block backs up and stops taking input.
    always @(posedge aclk) begin : result_monitor
        cwnd_result_t want;
        logic         ready_nxt;
        int           recv_stall_left;
        int           recv_hold_left;
        int           long_holds_served;
        if (!aresetn) begin
            m_ready           <= 1'b0;
            recv_stall_left   = 0;
            recv_hold_left    = 0;
            long_holds_served = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (window_reports_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result word with none expected: window %0d phase %0b",
                                 $realtime, m_cwnd_pkts, m_phase);
                    end
                end else begin
                    want = window_reports_due.pop_front();
                    if (m_cwnd_pkts !== want.cwnd_pkts || m_phase !== want.phase ||
                        m_threshold !== want.threshold ||
                        m_window_changed !== want.window_changed) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: result mismatch: window %0d (exp %0d), ",
                                     $realtime, m_cwnd_pkts, want.cwnd_pkts,
                                     "phase %0b (exp %0b), ", m_phase, want.phase,
                                     "threshold %0d (exp %0d), ",
                                     m_threshold, want.threshold,
                                     "changed %0b (exp %0b)",
                                     m_window_changed, want.window_changed);
                        end
                    end
                end
            end
            if (long_holds_served != long_holds_requested) begin
                long_holds_served++;
                recv_hold_left = HOLD_CYCLES;
            end
            if (recv_hold_left > 0) begin
                recv_hold_left--;
                ready_nxt = 1'b0;
            end else if (recv_stall_left > 0) begin
                recv_stall_left--;
                ready_nxt = 1'b0;
            end else if ($urandom_range(0, 99) < recv_stall_pct) begin
                recv_stall_left = $urandom_range(0, 10);
                ready_nxt       = 1'b0;
            end else begin
                ready_nxt = 1'b1;
            end
            m_ready <= ready_nxt;
        end
    end

    task automatic queue_event(input logic [1:0] mode, input logic [TIME_BITS-1:0] now_ms);
        cwnd_event_t ev;
        ev.mode   = mode;
        ev.now_ms = now_ms;
        events_to_send.push_back(ev);
    endtask

    // Returns on a falling edge once every queued word has been accepted and
    // every predicted result has come back, so the block sits idle.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (events_to_send.size() != 0 || s_valid || window_reports_due.size() != 0);
    endtask

    // Threshold register write; only called while the block is idle. The
    // write also reloads the live slow start threshold.
    task automatic write_threshold(input logic [WIN_BITS-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ssthresh  = value;
        @(negedge aclk);
    endtask

    // Stimulus: a directed opening, then phases of well-formed traffic with
    // a new threshold each, and a quiet tail.
    initial begin : stimulus
        logic [TIME_BITS-1:0] rtt_plan;
        logic [TIME_BITS-1:0] clk_ms;
        logic [TIME_BITS-1:0] avoid_start;
        logic [WIN_BITS-1:0]  thr_plan;
        int                   issued;
        int                   pick;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The RTT is measured once per run, so the seed picks it: mostly a
        // short one, sometimes a long one that keeps quotients small.
        rtt_plan = ($urandom_range(0, 3) == 0) ? $urandom_range(1000, 60000)
                                               : $urandom_range(1, 100);

        // Ack right after reset: elapsed time is zero, so no RTT is taken.
        queue_event(MODE_ACK, '0);
        queue_event(MODE_UNUSED, '1);
        // Loss in slow start enters avoidance with an unmeasured RTT, where
        // an ack must not grow the window.
        queue_event(MODE_LOSS, '1);
        queue_event(MODE_ACK, TIME_BITS'(5));
        queue_event(MODE_LOSS, TIME_BITS'(7));
        // Two losses with the window already at one: no change reported.
        queue_event(MODE_LOSS, TIME_BITS'(8));
        queue_event(MODE_LOSS, TIME_BITS'(9));
        // Mark then ack measures the RTT; the threshold is now the minimum.
        queue_event(MODE_MARK, TIME_BITS'(1000));
        queue_event(MODE_ACK, TIME_BITS'(1000) + rtt_plan);
        avoid_start = TIME_BITS'(1001) + rtt_plan;
        queue_event(MODE_ACK, avoid_start);
        // Avoidance growth by elapsed/RTT, then the largest elapsed time,
        // which pins the window at its maximum.
        queue_event(MODE_ACK, avoid_start + 6 * rtt_plan - 1);
        queue_event(MODE_ACK, avoid_start - 1);
        queue_event(MODE_ACK, avoid_start - 1);
        queue_event(MODE_UNUSED, '0);
        queue_event(MODE_LOSS, '0);
        // Time wraps from all ones to zero between mark and ack.
        queue_event(MODE_MARK, '1);
        queue_event(MODE_ACK, '0);
        queue_event(MODE_MARK, '0);
        queue_event(MODE_ACK, '1);
        wait_drained();

        clk_ms = avoid_start;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Thresholds below the legal minimum, both extremes, then random.
            case (ph)
                0:       thr_plan = '0;
                1:       thr_plan = WIN_BITS'(1);
                2:       thr_plan = MAX_WINDOW;
                3:       thr_plan = THRESH_MIN;
                default: thr_plan = ($urandom_range(0, 1) == 0) ?
                                    WIN_BITS'($urandom_range(2, 64)) :
                                    WIN_BITS'($urandom_range(2, 65535));
            endcase
            write_threshold(thr_plan);

            if (ph >= NUM_PHASES - 2) begin
                // No idling at all near the end of the run.
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end else if (ph == 2) begin
                // The receiver goes quiet while the sender keeps pushing.
                send_gap_pct   = 0;
                recv_stall_pct = 10;
                long_holds_requested++;
            end else begin
                send_gap_pct   = 12 * $urandom_range(0, 2);
                recv_stall_pct = 12 * $urandom_range(0, 2);
            end

            // Mostly acks spaced around one RTT apart, with losses and marks
            // mixed in; some words jump far ahead in time, some carry
            // unrelated timestamps, and a few use the unused mode.
            issued = 0;
            while (issued < PHASE_WORDS) begin
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    clk_ms += $urandom_range(0, 2 * rtt_plan);
                    queue_event(MODE_ACK, clk_ms);
                end else if (pick < 70) begin
                    clk_ms += $urandom_range(0, rtt_plan);
                    queue_event(MODE_LOSS, clk_ms);
                end else if (pick < 80) begin
                    clk_ms += $urandom_range(0, rtt_plan);
                    queue_event(MODE_MARK, clk_ms);
                end else if (pick < 84) begin
                    clk_ms += $urandom;
                    queue_event(MODE_ACK, clk_ms);
                end else if (pick < 93) begin
                    queue_event(2'($urandom_range(0, 2)), $urandom);
                end else begin
                    queue_event(MODE_UNUSED, $urandom);
                end
                issued++;
            end
            // The sender pauses here until every result of the phase is in.
            wait_drained();
        end

        // Anything the block emits now has no prediction behind it.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && window_reports_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog. A correct run needs well under 1.2 ms of simulated time,
    // even with every word on the divide path and every stall at its longest.
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
